// ----- rtl/four_node_graphlet_counter_assert.svh -----
// Assertion macros for the four-node graphlet counter.
// Needs a clock named clk and a synchronous reset named rst in the module.
`ifndef FOUR_NODE_GRAPHLET_COUNTER_ASSERT_SVH
`define FOUR_NODE_GRAPHLET_COUNTER_ASSERT_SVH
// Checked outside reset
`define FNGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked during reset too
`define FNGC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- rtl/fngc_pkg.sv -----
// Shared types, constants and helper functions for the graphlet counter.
// No dependencies.
package fngc_pkg;

  localparam int ROW_W             = 32;
  localparam int NODE_W            = 5;
  localparam int LOAD_W            = 6;
  localparam int CNT_W             = 20;
  localparam int TOT_W             = 23;
  localparam int COUNT_OUT_W       = 16;
  localparam int FREQ_W            = 17;
  localparam int NUM_CLASSES       = 6;
  localparam int DEF_MAX_NODES     = 32;
  localparam int DEF_FRACTION_BITS = 16;

  // Reciprocal of three: ceil(2^21 / 3), exact floor for any 20-bit operand
  localparam int               THIRD_SHIFT = CNT_W + 1;
  localparam logic [CNT_W-1:0] THIRD_MUL   = 20'hAAAAB;

  typedef enum logic [2:0] {
    CLS_CLIQUE  = 3'd0,
    CLS_DIAMOND = 3'd1,
    CLS_PAW     = 3'd2,
    CLS_STAR    = 3'd3,
    CLS_CYCLE   = 3'd4,
    CLS_PATH    = 3'd5
  } cls_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_RI_RD,
    ST_RI_WAIT,
    ST_WJ_PICK,
    ST_WJ_WAIT,
    ST_WK_PICK,
    ST_WK_WAIT,
    ST_WK_ADD,
    ST_SJ_PICK,
    ST_SJ_WAIT,
    ST_SK_PICK,
    ST_SK_WAIT,
    ST_SK_ADD,
    ST_NEXT_I,
    ST_DIVC_GO,
    ST_DIVC_WAIT,
    ST_FREQ_GO,
    ST_FREQ_WAIT
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] row_index;
    logic [ROW_W-1:0]  row_bits;
    logic              last_row;
  } item_t;

  typedef struct packed {
    logic [2:0]             graphlet_class;
    logic [COUNT_OUT_W-1:0] graphlet_count;
    logic [FREQ_W-1:0]      frequency;
    logic                   last_class;
  } result_t;

  // Power-of-two part of the walk multiplicity of each class
  function automatic logic [1:0] class_shift(input cls_t c);
    logic [1:0] s;
    case (c)
      CLS_CLIQUE:  s = 2'd3;
      CLS_DIAMOND: s = 2'd2;
      CLS_PAW:     s = 2'd2;
      CLS_STAR:    s = 2'd0;
      CLS_CYCLE:   s = 2'd3;
      CLS_PATH:    s = 2'd1;
      default:     s = 2'd0;
    endcase
    return s;
  endfunction

  // Classes whose multiplicity also carries a factor of three
  function automatic logic class_third(input cls_t c);
    logic f;
    case (c)
      CLS_CLIQUE:  f = 1'b1;
      CLS_DIAMOND: f = 1'b1;
      default:     f = 1'b0;
    endcase
    return f;
  endfunction

  // Index of the lowest set bit
  function automatic logic [NODE_W-1:0] lsb_index(input logic [ROW_W-1:0] v);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (v[b]) idx = NODE_W'(b);
    end
    return idx;
  endfunction

  // Population count, summed per byte then across bytes
  function automatic logic [LOAD_W-1:0] popcount(input logic [ROW_W-1:0] v);
    logic [3:0]        part [4];
    logic [LOAD_W-1:0] sum;
    for (int g = 0; g < 4; g++) begin
      part[g] = '0;
      for (int b = 0; b < 8; b++) begin
        part[g] = part[g] + 4'(v[g*8+b]);
      end
    end
    sum = LOAD_W'(part[0]) + LOAD_W'(part[1]) + LOAD_W'(part[2]) + LOAD_W'(part[3]);
    return sum;
  endfunction

endpackage

// ----- rtl/fngc_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module fngc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fngc_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the graphlet counter top level.
module fngc_div #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 23
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    steps;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Trial subtraction
  assign shifted = {rem, quot[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= CW'(NUM_W);
      end else if (steps != '0) begin
        steps <= steps - CW'(1);
        if (steps == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quot  <= num;
      den_q <= den;
    end else if (steps != '0) begin
      rem  <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/four_node_graphlet_counter.sv -----
// Top level of the four-node graphlet counter.
// Depends on fngc_pkg, fngc_ram, fngc_div and the assertion macro header.
//
// Usage:
//   Input channel: drive item and raise start; a beat is taken at an edge where
//   start is high and busy is low. Each beat with a row_index below the node
//   limit writes one adjacency row. A row beat without last_row leaves busy low.
//   The beat with last_row set closes the graph and raises busy while the
//   block counts. The count walks every path i-j-k through the read port of the
//   row RAM and adds population counts of 32-bit neighbour masks through one
//   shared popcount adder: for each node i it reads row i, for each neighbour j
//   row j, and for each two-step walk (k) row k, then adds four masks. A star
//   pass reads row k for each non-adjacent pair of neighbours of i and skips
//   adjacent pairs. The six walk tallies are then scaled by shift and, for
//   clique and diamond, reciprocal multiply, and each fraction goes through one
//   shared restoring divider, which is skipped when the total is zero.
//   Result channel: six beats, one per class, in class order, each held for one
//   cycle and flagged by result_valid, registered in the cycle after its divide (if any) ends;
//   the receiver cannot stall, so no beat waits. busy falls with the sixth beat.
//   Reset: the block is idle, no rows are loaded and the next row starts a
//   fresh graph. The row RAM itself is not cleared; per-row valid bits are.
module four_node_graphlet_counter
  import fngc_pkg::*;
#(
  parameter int MAX_NODES     = DEF_MAX_NODES,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    result_valid,
  output result_t result
);

  `include "four_node_graphlet_counter_assert.svh"

  localparam int NN    = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
  localparam int AW    = $clog2(NN);
  localparam int NUM_W = CNT_W + FRACTION_BITS + 1;

  state_t state, state_next;

  logic              accept;
  logic              fresh;
  logic [LOAD_W-1:0] loaded;
  logic [ROW_W-1:0]  valid;
  logic [LOAD_W-1:0] loaded_base;
  logic [ROW_W-1:0]  valid_base;
  logic [LOAD_W-1:0] loaded_next;
  logic [ROW_W-1:0]  valid_next;
  logic              idx_ok;

  logic [ROW_W-1:0]  rdata;
  logic [NODE_W-1:0] raddr;
  logic [NODE_W-1:0] rd_node;
  logic [ROW_W-1:0]  colmask;
  logic [ROW_W-1:0]  rd_eff;

  logic [NODE_W-1:0] i_node, j_node, k_node;
  logic [ROW_W-1:0]  ri, rj;
  logic [ROW_W-1:0]  jvec, kvec;
  logic [ROW_W-1:0]  lv, av, bv;
  logic              aik;
  logic [1:0]        t;
  logic [NODE_W-1:0] pick_j, pick_k;

  logic [CNT_W-1:0]  tally [NUM_CLASSES];
  logic [TOT_W-1:0]  total;
  cls_t              c;

  logic              add_en;
  cls_t              add_cls;
  logic [ROW_W-1:0]  add_vec;

  logic [CNT_W-1:0]   cdiv_shifted;
  logic [2*CNT_W-1:0] cdiv_prod;
  logic [CNT_W-1:0]   cdiv_q;

  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [TOT_W-1:0]  div_den;
  logic              div_done;
  logic [NUM_W-1:0]  div_quot;

  logic              emit;
  logic [FREQ_W-1:0] emit_freq;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign idx_ok = ({1'b0, item.row_index} < LOAD_W'(NN));
  assign pick_j = lsb_index(jvec);
  assign pick_k = lsb_index(kvec);

  // Row store
  fngc_ram #(.WIDTH(ROW_W), .DEPTH(NN)) u_rows (
    .clk   (clk),
    .we    (accept && idx_ok),
    .waddr (item.row_index[AW-1:0]),
    .wdata (item.row_bits),
    .raddr (raddr[AW-1:0]),
    .rdata (rdata)
  );

  // Loaded count and per-row valid bits; a fresh graph starts empty
  assign loaded_base = fresh ? '0 : loaded;
  assign valid_base  = fresh ? '0 : valid;

  always_comb begin
    loaded_next = loaded_base;
    valid_next  = valid_base;
    if (idx_ok) begin
      valid_next[item.row_index] = 1'b1;
      if ({1'b0, item.row_index} + LOAD_W'(1) > loaded_base) begin
        loaded_next = {1'b0, item.row_index} + LOAD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh  <= 1'b1;
      loaded <= '0;
      valid  <= '0;
    end else if (accept) begin
      fresh  <= item.last_row;
      loaded <= loaded_next;
      valid  <= valid_next;
    end
  end

  // Effective row: masked to loaded columns, diagonal dropped, empty if unloaded
  assign colmask = (loaded >= LOAD_W'(ROW_W)) ? '1 : ((ROW_W'(1) << loaded) - ROW_W'(1));
  assign rd_eff  = (valid[rd_node] && ({1'b0, rd_node} < loaded)) ?
                   (rdata & colmask & ~(ROW_W'(1) << rd_node)) : '0;

  always_ff @(posedge clk) begin
    rd_node <= raddr;
  end

  // Shared popcount adder operands
  always_comb begin
    add_en  = 1'b0;
    add_cls = CLS_STAR;
    add_vec = '0;
    if (state == ST_WK_ADD) begin
      add_en = 1'b1;
      case (t)
        2'd0: begin
          add_vec = av & bv;
          add_cls = aik ? CLS_CLIQUE : CLS_DIAMOND;
        end
        2'd1: begin
          add_vec = aik ? (av ^ bv) : (av & ~bv);
          add_cls = aik ? CLS_DIAMOND : CLS_CYCLE;
        end
        2'd2: begin
          add_vec = aik ? (lv & ~(av | bv)) : (bv & ~av);
          add_cls = CLS_PAW;
        end
        default: begin
          add_vec = aik ? '0 : (lv & ~(av | bv));
          add_cls = CLS_PATH;
        end
      endcase
    end else if (state == ST_SK_ADD) begin
      add_en  = 1'b1;
      add_vec = lv;
      add_cls = CLS_STAR;
    end
  end

  // Walk multiplicity removal: power-of-two shift, then for clique and diamond a third by reciprocal
  assign cdiv_shifted = tally[c] >> class_shift(c);
  assign cdiv_prod    = cdiv_shifted * THIRD_MUL;

  // Divider operands, fractions only
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state == ST_FREQ_GO && total != '0) begin
      div_start = 1'b1;
      div_num   = (NUM_W'(tally[c]) << FRACTION_BITS) + NUM_W'(total >> 1);
      div_den   = total;
    end
  end

  fngc_div #(.NUM_W(NUM_W), .DEN_W(TOT_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, RAM address and result strobe
  always_comb begin
    state_next = state;
    raddr      = i_node;
    emit       = 1'b0;
    emit_freq  = '0;
    case (state)
      ST_IDLE: begin
        if (accept && item.last_row) state_next = ST_START;
      end
      ST_START: begin
        state_next = (loaded == '0) ? ST_DIVC_GO : ST_RI_RD;
      end
      ST_RI_RD: begin
        raddr      = i_node;
        state_next = ST_RI_WAIT;
      end
      ST_RI_WAIT: state_next = ST_WJ_PICK;
      ST_WJ_PICK: begin
        raddr      = pick_j;
        state_next = (jvec == '0) ? ST_SJ_PICK : ST_WJ_WAIT;
      end
      ST_WJ_WAIT: state_next = ST_WK_PICK;
      ST_WK_PICK: begin
        raddr      = pick_k;
        state_next = (kvec == '0) ? ST_WJ_PICK : ST_WK_WAIT;
      end
      ST_WK_WAIT: state_next = ST_WK_ADD;
      ST_WK_ADD: begin
        if (t == 2'd3) state_next = ST_WK_PICK;
      end
      ST_SJ_PICK: begin
        raddr      = pick_j;
        state_next = (jvec == '0) ? ST_NEXT_I : ST_SJ_WAIT;
      end
      ST_SJ_WAIT: state_next = ST_SK_PICK;
      ST_SK_PICK: begin
        raddr = pick_k;
        if (kvec == '0) begin
          state_next = ST_SJ_PICK;
        end else if (!rj[pick_k]) begin
          state_next = ST_SK_WAIT;
        end
      end
      ST_SK_WAIT: state_next = ST_SK_ADD;
      ST_SK_ADD:  state_next = ST_SK_PICK;
      ST_NEXT_I: begin
        state_next = ({1'b0, i_node} + LOAD_W'(1) == loaded) ? ST_DIVC_GO : ST_RI_RD;
      end
      ST_DIVC_GO: state_next = ST_DIVC_WAIT;
      ST_DIVC_WAIT: begin
        state_next = (c == CLS_PATH) ? ST_FREQ_GO : ST_DIVC_GO;
      end
      ST_FREQ_GO: begin
        if (total == '0) begin
          emit       = 1'b1;
          state_next = (c == CLS_PATH) ? ST_IDLE : ST_FREQ_GO;
        end else begin
          state_next = ST_FREQ_WAIT;
        end
      end
      ST_FREQ_WAIT: begin
        if (div_done) begin
          emit       = 1'b1;
          emit_freq  = div_quot[FREQ_W-1:0];
          state_next = (c == CLS_PATH) ? ST_IDLE : ST_FREQ_GO;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Walk, star and scaling datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_START: begin
        i_node <= '0;
        c      <= CLS_CLIQUE;
        total  <= '0;
        for (int n = 0; n < NUM_CLASSES; n++) tally[n] <= '0;
      end
      ST_RI_WAIT: begin
        ri   <= rd_eff;
        jvec <= rd_eff;
      end
      ST_WJ_PICK: begin
        if (jvec != '0) begin
          jvec[pick_j] <= 1'b0;
          j_node       <= pick_j;
        end else begin
          jvec <= ri;
        end
      end
      ST_WJ_WAIT: begin
        rj   <= rd_eff;
        kvec <= rd_eff & ~(ROW_W'(1) << i_node);
      end
      ST_WK_PICK: begin
        if (kvec != '0) begin
          kvec[pick_k] <= 1'b0;
          k_node       <= pick_k;
          aik          <= ri[pick_k];
        end
      end
      ST_WK_WAIT: begin
        lv <= rd_eff & ~(ROW_W'(1) << i_node) & ~(ROW_W'(1) << j_node);
        av <= rd_eff & ~(ROW_W'(1) << i_node) & ~(ROW_W'(1) << j_node) & ri;
        bv <= rd_eff & ~(ROW_W'(1) << i_node) & ~(ROW_W'(1) << j_node) & rj;
        t  <= 2'd0;
      end
      ST_WK_ADD: t <= t + 2'd1;
      ST_SJ_PICK: begin
        if (jvec != '0) begin
          jvec[pick_j] <= 1'b0;
          j_node       <= pick_j;
        end
      end
      ST_SJ_WAIT: begin
        rj   <= rd_eff;
        kvec <= ri & (ROW_W'('1) << j_node << 1);
      end
      ST_SK_PICK: begin
        if (kvec != '0) begin
          kvec[pick_k] <= 1'b0;
          k_node       <= pick_k;
        end
      end
      ST_SK_WAIT: begin
        lv <= ri & ~rj & ~rd_eff & (ROW_W'('1) << k_node << 1);
      end
      ST_NEXT_I: i_node <= i_node + NODE_W'(1);
      ST_DIVC_GO: begin
        cdiv_q <= class_third(c) ? {1'b0, cdiv_prod[2*CNT_W-1:THIRD_SHIFT]} : cdiv_shifted;
      end
      ST_DIVC_WAIT: begin
        tally[c] <= cdiv_q;
        total    <= total + TOT_W'(cdiv_q);
        c        <= (c == CLS_PATH) ? CLS_CLIQUE : cls_t'(c + 3'd1);
      end
      ST_FREQ_GO, ST_FREQ_WAIT: begin
        if (emit) c <= cls_t'(c + 3'd1);
      end
      default: ;
    endcase
    // Shared popcount accumulate
    if (add_en) begin
      tally[add_cls] <= tally[add_cls] + CNT_W'(popcount(add_vec));
    end
  end

  // Result beat, one cycle wide
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.graphlet_class <= c;
      result.graphlet_count <= (tally[c] > CNT_W'(16'hFFFF)) ? 16'hFFFF :
                               tally[c][COUNT_OUT_W-1:0];
      result.frequency      <= emit_freq;
      result.last_class     <= (c == CLS_PATH);
    end
  end

  // Checks
  `FNGC_ASSERT(a_busy_mid_burst, result_valid && !result.last_class |-> busy,
               "idle before final beat")
  `FNGC_ASSERT(a_idle_after_last, result_valid && result.last_class |-> !busy,
               "still busy after final beat")
  `FNGC_ASSERT(a_last_row_busy, start && !busy && item.last_row |=> busy,
               "last row did not start counting")
  `FNGC_ASSERT_ALWAYS(a_no_beat_in_reset, $past(rst) |-> !result_valid,
                      "result beat straight after reset")

endmodule
